@@ rtl/core/rotation_matrix_generator_assert.svh @@
// Assertion macros for the checker of the rotation matrix generator.
`ifndef ROTATION_MATRIX_GENERATOR_ASSERT_SVH
`define ROTATION_MATRIX_GENERATOR_ASSERT_SVH

// Same-cycle implication, clocked on clk, disabled during rst.
`define RMG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, disabled during rst.
`define RMG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/rmg_pkg.sv @@
// Package of types, constants and helper functions for the rotation matrix generator.
package rmg_pkg;

  localparam int ANGLE_BITS    = 16;
  localparam int FRAC_BITS     = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int SQRT_STEPS    = 32;
  localparam int INV_BITS      = 47;
  localparam int OUT_W         = FRAC_BITS + 2;

  localparam logic [2:0] OP_ROT_X = 3'd0;
  localparam logic [2:0] OP_ROT_Y = 3'd1;
  localparam logic [2:0] OP_ROT_Z = 3'd2;
  localparam logic [2:0] OP_ROT_V = 3'd3;
  localparam logic [2:0] OP_REF_X = 3'd4;
  localparam logic [2:0] OP_REF_Y = 3'd5;
  localparam logic [2:0] OP_REF_Z = 3'd6;

  typedef logic signed [33:0] cw_t;
  typedef logic signed [OUT_W-1:0] ent_t;

  localparam cw_t CORDIC_GAIN = 34'sd652032874;
  localparam ent_t ONE_Q = ent_t'(1) <<< FRAC_BITS;

  typedef struct packed {
    logic [2:0]         opcode;
    logic               improper;
    logic [15:0]        angle;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic               zero;
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [31:0] nz;
  } tag_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  // saturate a Q30 value to +-1.0
  function automatic logic signed [31:0] clamp30(input cw_t v);
    logic signed [31:0] r;
    if (v > cw_t'(1) <<< 30) r = 32'sd1 <<< 30;
    else if (v < -(cw_t'(1) <<< 30)) r = -(32'sd1 <<< 30);
    else r = v[31:0];
    return r;
  endfunction

  // Q30 to Q1.FRAC_BITS, round half up, saturate
  function automatic ent_t frac30(input logic signed [31:0] v);
    logic signed [32:0] t;
    t = (33'(v) + (33'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    if (t > (33'sd1 <<< FRAC_BITS)) return ONE_Q;
    else if (t < -(33'sd1 <<< FRAC_BITS)) return -ONE_Q;
    else return t[OUT_W-1:0];
  endfunction

  // Q60 with rounding half already added, to Q1.FRAC_BITS, saturate
  function automatic ent_t frac60(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = v >>> (60 - FRAC_BITS);
    if (t > (64'sd1 <<< FRAC_BITS)) return ONE_Q;
    else if (t < -(64'sd1 <<< FRAC_BITS)) return -ONE_Q;
    else return t[OUT_W-1:0];
  endfunction

endpackage

@@ rtl/core/rotation_matrix_generator.sv @@
// Top level of the rotation matrix generator: axis normalization, CORDIC and matrix assembly.
// Takes one request word per clock while s_axis_tready is high and returns one 3x3 Q1.16
// matrix word per request, in order. A request passes through these cell chains:
// one squaring stage, 32 square-root cells, 47 divider cells for the reciprocal, two
// normalization stages, 16 CORDIC cells, four Rodrigues product and sum stages and the
// output register. The whole chain advances together; it holds only while the output
// register carries a word that the sink has not taken, so s_axis_tready is low only then.
module rotation_matrix_generator (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,  // angle, axis_x, axis_y, axis_z
  input  logic [3:0]   s_axis_tuser,  // opcode, improper
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [167:0] m_axis_tdata,  // m00, m01, m02, m10, m11, m12, m20, m21, m22, zero pad
  output logic [0:0]   m_axis_tuser   // zero_axis_error
);
  import rmg_pkg::*;

  localparam logic signed [63:0] HALF60 = 64'sd1 <<< (59 - FRAC_BITS);
  localparam logic signed [63:0] ONE60  = 64'sd1 <<< 60;

  logic en;
  logic out_vld;

  assign en            = !out_vld || m_axis_tready;
  assign s_axis_tready = en;

  // squaring stage
  tag_t               s1_tag;
  tag_t               in_tag;
  logic               s1_vld;
  logic [31:0]        s1_sum;
  logic signed [31:0] sqx, sqy, sqz;

  always_comb begin
    in_tag          = '0;
    in_tag.opcode   = s_axis_tuser[2:0];
    in_tag.improper = s_axis_tuser[3];
    in_tag.angle    = s_axis_tdata[15:0];
    in_tag.axis_x   = s_axis_tdata[31:16];
    in_tag.axis_y   = s_axis_tdata[47:32];
    in_tag.axis_z   = s_axis_tdata[63:48];
    in_tag.zero     = (s_axis_tdata[63:16] == 48'd0);
  end

  assign sqx = in_tag.axis_x * in_tag.axis_x;
  assign sqy = in_tag.axis_y * in_tag.axis_y;
  assign sqz = in_tag.axis_z * in_tag.axis_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_tag <= in_tag;
      s1_sum <= 32'(sqx) + 32'(sqy) + 32'(sqz);
    end
  end

  // square root chain
  logic        sq_vld  [0:SQRT_STEPS];
  tag_t        sq_tag  [0:SQRT_STEPS];
  logic [63:0] sq_rem  [0:SQRT_STEPS];
  logic [63:0] sq_root [0:SQRT_STEPS];

  assign sq_vld[0]  = s1_vld;
  assign sq_tag[0]  = s1_tag;
  assign sq_rem[0]  = {s1_sum, 32'd0};
  assign sq_root[0] = 64'd0;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    rmg_sqrt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .step     (5'(k)),
      .in_vld   (sq_vld[k]),
      .in_tag   (sq_tag[k]),
      .in_rem   (sq_rem[k]),
      .in_root  (sq_root[k]),
      .out_vld  (sq_vld[k+1]),
      .out_tag  (sq_tag[k+1]),
      .out_rem  (sq_rem[k+1]),
      .out_root (sq_root[k+1])
    );
  end

  // reciprocal chain
  logic                dv_vld [0:INV_BITS];
  tag_t                dv_tag [0:INV_BITS];
  logic [32:0]         dv_rem [0:INV_BITS];
  logic [31:0]         dv_r   [0:INV_BITS];
  logic [INV_BITS-1:0] dv_q   [0:INV_BITS];

  assign dv_vld[0] = sq_vld[SQRT_STEPS];
  assign dv_tag[0] = sq_tag[SQRT_STEPS];
  assign dv_rem[0] = 33'd1 << (62 - INV_BITS);
  assign dv_r[0]   = sq_root[SQRT_STEPS][31:0];
  assign dv_q[0]   = '0;

  for (genvar k = 0; k < INV_BITS; k++) begin : g_div
    rmg_div_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .in_vld  (dv_vld[k]),
      .in_tag  (dv_tag[k]),
      .in_rem  (dv_rem[k]),
      .in_r    (dv_r[k]),
      .in_q    (dv_q[k]),
      .out_vld (dv_vld[k+1]),
      .out_tag (dv_tag[k+1]),
      .out_rem (dv_rem[k+1]),
      .out_r   (dv_r[k+1]),
      .out_q   (dv_q[k+1])
    );
  end

  // normalization: |a| * inv in two partial products, then shift and saturate
  logic               n1_vld;
  tag_t               n1_tag;
  logic [39:0]        n1_plo [3];
  logic [38:0]        n1_phi [3];
  logic               n1_sgn [3];
  logic signed [15:0] ax_in  [3];
  logic [15:0]        mag    [3];
  logic [INV_BITS-1:0] inv;

  assign inv      = dv_q[INV_BITS];
  assign ax_in[0] = dv_tag[INV_BITS].axis_x;
  assign ax_in[1] = dv_tag[INV_BITS].axis_y;
  assign ax_in[2] = dv_tag[INV_BITS].axis_z;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      mag[j] = ax_in[j][15] ? (~ax_in[j] + 16'd1) : ax_in[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n1_vld <= 1'b0;
    end else if (en) begin
      n1_vld <= dv_vld[INV_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1_tag <= dv_tag[INV_BITS];
      for (int j = 0; j < 3; j++) begin
        n1_plo[j] <= mag[j] * inv[23:0];
        n1_phi[j] <= mag[j] * inv[INV_BITS-1:24];
        n1_sgn[j] <= ax_in[j][15];
      end
    end
  end

  logic               n2_vld;
  tag_t               n2_tag;
  tag_t               n2_tag_next;
  logic [62:0]        full   [3];
  logic [30:0]        nmag   [3];
  logic signed [31:0] nval   [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      full[j] = {n1_phi[j], 24'd0} + 63'(n1_plo[j]);
      nmag[j] = (full[j][62:16] > 47'(1 << 30)) ? 31'(1 << 30) : full[j][46:16];
      nval[j] = n1_sgn[j] ? -$signed({1'b0, nmag[j]}) : $signed({1'b0, nmag[j]});
    end
    n2_tag_next    = n1_tag;
    n2_tag_next.nx = nval[0];
    n2_tag_next.ny = nval[1];
    n2_tag_next.nz = nval[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n2_vld <= 1'b0;
    end else if (en) begin
      n2_vld <= n1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n2_tag <= n2_tag_next;
    end
  end

  // CORDIC chain
  logic cr_vld [0:CORDIC_STAGES];
  tag_t cr_tag [0:CORDIC_STAGES];
  cw_t  cr_x   [0:CORDIC_STAGES];
  cw_t  cr_y   [0:CORDIC_STAGES];
  cw_t  cr_z   [0:CORDIC_STAGES];

  assign cr_vld[0] = n2_vld;
  assign cr_tag[0] = n2_tag;
  assign cr_x[0]   = CORDIC_GAIN;
  assign cr_y[0]   = '0;
  assign cr_z[0]   = cw_t'(n2_tag.angle[ANGLE_BITS-3:0]) <<< (32 - ANGLE_BITS);

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    rmg_cordic_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .step    (5'(k)),
      .in_vld  (cr_vld[k]),
      .in_tag  (cr_tag[k]),
      .in_x    (cr_x[k]),
      .in_y    (cr_y[k]),
      .in_z    (cr_z[k]),
      .out_vld (cr_vld[k+1]),
      .out_tag (cr_tag[k+1]),
      .out_x   (cr_x[k+1]),
      .out_y   (cr_y[k+1]),
      .out_z   (cr_z[k+1])
    );
  end

  // F1: quadrant fold, axis outer products
  tag_t               ct;
  cw_t                craw, sraw;
  logic               f1_vld;
  tag_t               f1_tag;
  logic signed [31:0] f1_c, f1_s;
  logic signed [63:0] f1_xx, f1_yy, f1_zz, f1_xy, f1_xz, f1_yz;

  assign ct = cr_tag[CORDIC_STAGES];

  always_comb begin
    case (ct.angle[ANGLE_BITS-1:ANGLE_BITS-2])
      2'd0: begin
        craw = cr_x[CORDIC_STAGES];
        sraw = cr_y[CORDIC_STAGES];
      end
      2'd1: begin
        craw = -cr_y[CORDIC_STAGES];
        sraw = cr_x[CORDIC_STAGES];
      end
      2'd2: begin
        craw = -cr_x[CORDIC_STAGES];
        sraw = -cr_y[CORDIC_STAGES];
      end
      default: begin
        craw = cr_y[CORDIC_STAGES];
        sraw = -cr_x[CORDIC_STAGES];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_vld <= 1'b0;
    end else if (en) begin
      f1_vld <= cr_vld[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_tag <= ct;
      f1_c   <= clamp30(craw);
      f1_s   <= clamp30(sraw);
      f1_xx  <= ct.nx * ct.nx;
      f1_yy  <= ct.ny * ct.ny;
      f1_zz  <= ct.nz * ct.nz;
      f1_xy  <= ct.nx * ct.ny;
      f1_xz  <= ct.nx * ct.nz;
      f1_yz  <= ct.ny * ct.nz;
    end
  end

  // F2: K*K entries and 1 - cos
  logic               f2_vld;
  tag_t               f2_tag;
  logic signed [31:0] f2_c, f2_s;
  logic signed [32:0] f2_omc;
  logic signed [32:0] f2_k00, f2_k11, f2_k22, f2_k01, f2_k02, f2_k12;
  logic signed [63:0] t00, t11, t22, t01, t02, t12;

  assign t00 = (f1_yy + f1_zz) >>> 30;
  assign t11 = (f1_xx + f1_zz) >>> 30;
  assign t22 = (f1_xx + f1_yy) >>> 30;
  assign t01 = f1_xy >>> 30;
  assign t02 = f1_xz >>> 30;
  assign t12 = f1_yz >>> 30;

  always_ff @(posedge clk) begin
    if (rst) begin
      f2_vld <= 1'b0;
    end else if (en) begin
      f2_vld <= f1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f2_tag <= f1_tag;
      f2_c   <= f1_c;
      f2_s   <= f1_s;
      f2_omc <= (33'sd1 <<< 30) - 33'(f1_c);
      f2_k00 <= -t00[32:0];
      f2_k11 <= -t11[32:0];
      f2_k22 <= -t22[32:0];
      f2_k01 <= t01[32:0];
      f2_k02 <= t02[32:0];
      f2_k12 <= t12[32:0];
    end
  end

  // F3: Rodrigues products, single-axis entries
  logic               f3_vld;
  tag_t               f3_tag;
  ent_t               f3_cf, f3_sf;
  logic signed [63:0] f3_o00, f3_o11, f3_o22, f3_o01, f3_o02, f3_o12;
  logic signed [63:0] f3_sx, f3_sy, f3_sz;
  logic signed [65:0] p00, p11, p22, p01, p02, p12;

  assign p00 = f2_omc * f2_k00;
  assign p11 = f2_omc * f2_k11;
  assign p22 = f2_omc * f2_k22;
  assign p01 = f2_omc * f2_k01;
  assign p02 = f2_omc * f2_k02;
  assign p12 = f2_omc * f2_k12;

  always_ff @(posedge clk) begin
    if (rst) begin
      f3_vld <= 1'b0;
    end else if (en) begin
      f3_vld <= f2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f3_tag <= f2_tag;
      f3_cf  <= frac30(f2_c);
      f3_sf  <= frac30(f2_s);
      f3_o00 <= p00[63:0];
      f3_o11 <= p11[63:0];
      f3_o22 <= p22[63:0];
      f3_o01 <= p01[63:0];
      f3_o02 <= p02[63:0];
      f3_o12 <= p12[63:0];
      f3_sx  <= f2_s * f2_tag.nx;
      f3_sy  <= f2_s * f2_tag.ny;
      f3_sz  <= f2_s * f2_tag.nz;
    end
  end

  // F4: Q60 sums with rounding half folded in
  logic               f4_vld;
  tag_t               f4_tag;
  ent_t               f4_cf, f4_sf;
  logic signed [63:0] f4_a [9];

  always_ff @(posedge clk) begin
    if (rst) begin
      f4_vld <= 1'b0;
    end else if (en) begin
      f4_vld <= f3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f4_tag  <= f3_tag;
      f4_cf   <= f3_cf;
      f4_sf   <= f3_sf;
      f4_a[0] <= ONE60 + HALF60 + f3_o00;
      f4_a[1] <= f3_o01 - f3_sz + HALF60;
      f4_a[2] <= f3_o02 + f3_sy + HALF60;
      f4_a[3] <= f3_o01 + f3_sz + HALF60;
      f4_a[4] <= ONE60 + HALF60 + f3_o11;
      f4_a[5] <= f3_o12 - f3_sx + HALF60;
      f4_a[6] <= f3_o02 - f3_sy + HALF60;
      f4_a[7] <= f3_o12 + f3_sx + HALF60;
      f4_a[8] <= ONE60 + HALF60 + f3_o22;
    end
  end

  // output stage: select by opcode, improper negate
  ent_t m      [9];
  ent_t m_next [9];
  logic err, err_next;
  logic negate;

  always_comb begin
    for (int j = 0; j < 9; j++) begin
      m_next[j] = '0;
    end
    m_next[0] = ONE_Q;
    m_next[4] = ONE_Q;
    m_next[8] = ONE_Q;
    err_next  = 1'b0;
    negate    = 1'b0;
    case (f4_tag.opcode)
      OP_ROT_X: begin
        m_next[4] = f4_cf;
        m_next[5] = -f4_sf;
        m_next[7] = f4_sf;
        m_next[8] = f4_cf;
        negate    = f4_tag.improper;
      end
      OP_ROT_Y: begin
        m_next[0] = f4_cf;
        m_next[2] = f4_sf;
        m_next[6] = -f4_sf;
        m_next[8] = f4_cf;
        negate    = f4_tag.improper;
      end
      OP_ROT_Z: begin
        m_next[0] = f4_cf;
        m_next[1] = -f4_sf;
        m_next[3] = f4_sf;
        m_next[4] = f4_cf;
        negate    = f4_tag.improper;
      end
      OP_ROT_V: begin
        if (f4_tag.zero) begin
          err_next = 1'b1;
        end else begin
          for (int j = 0; j < 9; j++) begin
            m_next[j] = frac60(f4_a[j]);
          end
          negate = f4_tag.improper;
        end
      end
      OP_REF_X: m_next[0] = -ONE_Q;
      OP_REF_Y: m_next[4] = -ONE_Q;
      OP_REF_Z: m_next[8] = -ONE_Q;
      default: ;
    endcase
    if (negate) begin
      for (int j = 0; j < 9; j++) begin
        m_next[j] = -m_next[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= f4_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m   <= m_next;
      err <= err_next;
    end
  end

  assign m_axis_tvalid = out_vld;
  assign m_axis_tuser  = err;
  assign m_axis_tdata  = {6'd0, m[8], m[7], m[6], m[5], m[4], m[3], m[2], m[1], m[0]};

endmodule

@@ rtl/core/rmg_sqrt_cell.sv @@
// One step of the bit-serial square root chain: two radicand bits per cell.
module rmg_sqrt_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic [4:0]    step,
  input  logic          in_vld,
  input  rmg_pkg::tag_t in_tag,
  input  logic [63:0]   in_rem,
  input  logic [63:0]   in_root,
  output logic          out_vld,
  output rmg_pkg::tag_t out_tag,
  output logic [63:0]   out_rem,
  output logic [63:0]   out_root
);
  import rmg_pkg::*;

  logic [63:0] bitv;
  logic [64:0] trial;
  logic        take;

  assign bitv  = 64'd1 << (6'd62 - {step, 1'b0});
  assign trial = {1'b0, in_root} + {1'b0, bitv};
  assign take  = {1'b0, in_rem} >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tag <= in_tag;
      if (take) begin
        out_rem  <= in_rem - trial[63:0];
        out_root <= (in_root >> 1) + bitv;
      end else begin
        out_rem  <= in_rem;
        out_root <= in_root >> 1;
      end
    end
  end

endmodule

@@ rtl/core/rmg_div_cell.sv @@
// One quotient bit of the restoring divider chain that forms 2^62 / root.
module rmg_div_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_vld,
  input  rmg_pkg::tag_t                in_tag,
  input  logic [32:0]                  in_rem,
  input  logic [31:0]                  in_r,
  input  logic [rmg_pkg::INV_BITS-1:0] in_q,
  output logic                         out_vld,
  output rmg_pkg::tag_t                out_tag,
  output logic [32:0]                  out_rem,
  output logic [31:0]                  out_r,
  output logic [rmg_pkg::INV_BITS-1:0] out_q
);
  import rmg_pkg::*;

  logic [32:0] rem2;
  logic        take;

  assign rem2 = {in_rem[31:0], 1'b0};
  assign take = rem2 >= {1'b0, in_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tag <= in_tag;
      out_r   <= in_r;
      out_rem <= take ? rem2 - {1'b0, in_r} : rem2;
      out_q   <= {in_q[INV_BITS-2:0], take};
    end
  end

endmodule

@@ rtl/core/rmg_cordic_cell.sv @@
// One rotation-mode CORDIC micro-rotation.
module rmg_cordic_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic [4:0]    step,
  input  logic          in_vld,
  input  rmg_pkg::tag_t in_tag,
  input  rmg_pkg::cw_t  in_x,
  input  rmg_pkg::cw_t  in_y,
  input  rmg_pkg::cw_t  in_z,
  output logic          out_vld,
  output rmg_pkg::tag_t out_tag,
  output rmg_pkg::cw_t  out_x,
  output rmg_pkg::cw_t  out_y,
  output rmg_pkg::cw_t  out_z
);
  import rmg_pkg::*;

  cw_t at;
  cw_t xs;
  cw_t ys;

  assign at = cw_t'(atan_turn(step));
  assign xs = in_x >>> step;
  assign ys = in_y >>> step;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tag <= in_tag;
      if (!in_z[33]) begin
        out_x <= in_x - ys;
        out_y <= in_y + xs;
        out_z <= in_z - at;
      end else begin
        out_x <= in_x + ys;
        out_y <= in_y - xs;
        out_z <= in_z + at;
      end
    end
  end

endmodule

@@ rtl/core/rmg_checker.sv @@
// Port-level checker for the rotation matrix generator, bound to the top level.
module rmg_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [63:0]  s_axis_tdata,
  input logic [3:0]   s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [167:0] m_axis_tdata,
  input logic [0:0]   m_axis_tuser
);
`include "rotation_matrix_generator_assert.svh"

  localparam logic [167:0] IDENTITY = {6'd0, 18'h10000, 18'h0, 18'h0, 18'h0,
                                       18'h10000, 18'h0, 18'h0, 18'h0, 18'h10000};

  `RMG_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output word dropped while stalled")
  `RMG_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser), "output word changed while stalled")
  `RMG_ASSERT_NOW(a_err_ident, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == IDENTITY, "zero axis error without identity matrix")
  `RMG_ASSERT_NOW(a_ready_stall, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled without a pending output word")

endmodule

bind rotation_matrix_generator rmg_checker u_rmg_checker (.*);
